>>> rtl/upd_pkg.sv
// upd_pkg: shared types, character constants and hex helpers for the
// percent decoder. No dependencies.

package upd_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned MaxResults = 3;

   localparam logic [CharWidth-1:0] CharPlus    = 8'h2B;  // '+'
   localparam logic [CharWidth-1:0] CharPercent = 8'h25;  // '%'
   localparam logic [CharWidth-1:0] CharSpace   = 8'h20;  // ' '
   localparam logic [CharWidth-1:0] CharZero    = 8'h30;  // '0'
   localparam logic [CharWidth-1:0] CharNine    = 8'h39;  // '9'
   localparam logic [CharWidth-1:0] CharUpperA  = 8'h41;  // 'A'
   localparam logic [CharWidth-1:0] CharUpperF  = 8'h46;  // 'F'
   localparam logic [CharWidth-1:0] CharLowerA  = 8'h61;  // 'a'
   localparam logic [CharWidth-1:0] CharLowerF  = 8'h66;  // 'f'
   localparam logic [3:0]           LetterBase  = 4'd10;  // 'A' + 10 offset

   typedef struct packed {
      logic [CharWidth-1:0] char_in;
      logic                 final_byte;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_out;
      logic                 end_of_string;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_PCT  = 3'b010,
      PH_DIG  = 3'b100
   } phase_type;

   // Decoder result for one input beat
   typedef struct packed {
      logic [1:0]                            count;
      logic [MaxResults-1:0][CharWidth-1:0]  chars;
      logic [MaxResults-1:0]                 ends;
      phase_type                             phase;
      logic [CharWidth-1:0]                  held;
   } dec_type;

   function automatic logic is_hex(input logic [CharWidth-1:0] c);
      return ((c >= CharZero)   && (c <= CharNine))   ||
             ((c >= CharLowerA) && (c <= CharLowerF)) ||
             ((c >= CharUpperA) && (c <= CharUpperF));
   endfunction

   // Letters: low nibble of 'A'/'a' is 1, so value = nibble - 1 + 10
   function automatic logic [3:0] hex_val(input logic [CharWidth-1:0] c);
      logic [3:0] v;
      if ((c >= CharZero) && (c <= CharNine)) begin
         v = c[3:0];
      end else begin
         v = c[3:0] - 4'd1 + LetterBase;
      end
      return v;
   endfunction

endpackage

>>> rtl/url_percent_decoder.sv
// url_percent_decoder: top level of the streaming form/percent decoder.
// Depends on upd_pkg and upd_decode.

// Decodes a form-encoded string arriving one byte per req beat, final_byte
// set on its last byte. '+' gives a space, "%%" gives '%', '%' plus two hex
// digits (either case) gives that byte; a broken escape is passed through
// literally and what follows is decoded as normal. On the final byte any
// pending '%' / held digit is flushed and end_of_string marks the last rsp
// beat of the string. Each req beat yields zero to three rsp beats. Timing:
// the decode is one combinational pass from the phase/held-digit registers
// into a three-entry result buffer, which drains one rsp beat per cycle of
// rsp_ready. req_ready is high when the buffer is empty or its last entry
// leaves this cycle, so while rsp_ready is high a byte yielding at most one
// result is taken every cycle; one yielding more holds off the next byte
// until only its last result is left. No clearing pass after reset.

module url_percent_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  upd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output upd_pkg::rsp_type rsp_data
);

   // decode state
   upd_pkg::phase_type              phase_ff, phase_in;
   logic [upd_pkg::CharWidth-1:0]   held_ff, held_in;

   // result buffer: entry 0 is the head
   upd_pkg::rsp_type                slot_ff [upd_pkg::MaxResults];
   upd_pkg::rsp_type                slot_in [upd_pkg::MaxResults];
   logic [1:0]                      count_ff, count_in;

   upd_pkg::dec_type                dec;
   logic                            req_fire;
   logic                            rsp_fire;

   upd_decode u_decode (
      .req   (req_data),
      .phase (phase_ff),
      .held  (held_ff),
      .dec   (dec)
   );

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[0];
   assign rsp_fire  = rsp_valid && rsp_ready;
   // buffer must be empty after this cycle's pop before a new beat lands
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      count_in = count_ff;
      for (int i = 0; i < upd_pkg::MaxResults; i++) begin
         slot_in[i] = slot_ff[i];
      end

      if (req_fire) begin
         phase_in = dec.phase;
         held_in  = dec.held;
         count_in = dec.count;
         for (int i = 0; i < upd_pkg::MaxResults; i++) begin
            slot_in[i].char_out      = dec.chars[i];
            slot_in[i].end_of_string = dec.ends[i];
         end
      end else if (rsp_fire) begin
         count_in = count_ff - 2'd1;
         for (int i = 0; i < upd_pkg::MaxResults - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PH_IDLE;
         held_ff  <= '0;
         count_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < upd_pkg::MaxResults; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // ---- assertions ----

   // last byte always returns the decoder to idle
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.final_byte |=> phase_ff == upd_pkg::PH_IDLE)
      else $error("phase not idle after final byte");

   // last byte always produces at least one result
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.final_byte |=> count_ff != 2'd0)
      else $error("final byte produced no result");

   // the end marker is only ever in the last buffered entry
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_string |-> count_ff == 2'd1)
      else $error("end marker ahead of further results");

endmodule

>>> rtl/upd_decode.sv
// upd_decode: combinational next-state and result bytes for one input beat.
// Depends on upd_pkg.

module upd_decode (
   input  upd_pkg::req_type   req,
   input  upd_pkg::phase_type phase,
   input  logic [upd_pkg::CharWidth-1:0] held,
   output upd_pkg::dec_type   dec
);

   logic [1:0]                                                 idx;
   logic [upd_pkg::MaxResults-1:0][upd_pkg::CharWidth-1:0]     chars;
   logic [upd_pkg::MaxResults-1:0]                             ends;
   upd_pkg::phase_type                                         nxt_phase;
   logic [upd_pkg::CharWidth-1:0]                              nxt_held;
   logic                                                       take_idle;
   logic [upd_pkg::CharWidth-1:0]                              c;
   logic                                                       c_hex;

   assign c     = req.char_in;
   assign c_hex = upd_pkg::is_hex(c);

   always_comb begin
      idx       = 2'd0;
      chars     = '0;
      ends      = '0;
      nxt_phase = upd_pkg::PH_IDLE;
      nxt_held  = held;
      take_idle = 1'b0;

      unique case (phase)
         upd_pkg::PH_PCT: begin
            if (c == upd_pkg::CharPercent) begin
               chars[idx] = upd_pkg::CharPercent;
               idx        = idx + 2'd1;
            end else if (c_hex) begin
               nxt_held  = c;
               nxt_phase = upd_pkg::PH_DIG;
            end else begin
               chars[idx] = upd_pkg::CharPercent;
               idx        = idx + 2'd1;
               take_idle  = 1'b1;
            end
         end
         upd_pkg::PH_DIG: begin
            if (c_hex) begin
               chars[idx] = {upd_pkg::hex_val(held), upd_pkg::hex_val(c)};
               idx        = idx + 2'd1;
            end else begin
               // broken escape: '%' and the held digit go out literally
               chars[idx] = upd_pkg::CharPercent;
               idx        = idx + 2'd1;
               chars[idx] = held;
               idx        = idx + 2'd1;
               take_idle  = 1'b1;
            end
         end
         default: begin
            take_idle = 1'b1;
         end
      endcase

      if (take_idle) begin
         priority if (c == upd_pkg::CharPlus) begin
            chars[idx] = upd_pkg::CharSpace;
            idx        = idx + 2'd1;
         end else if (c == upd_pkg::CharPercent) begin
            nxt_phase = upd_pkg::PH_PCT;
         end else begin
            chars[idx] = c;
            idx        = idx + 2'd1;
         end
      end

      // flush any pending escape on the last byte
      if (req.final_byte) begin
         if (nxt_phase == upd_pkg::PH_PCT) begin
            chars[idx] = upd_pkg::CharPercent;
            idx        = idx + 2'd1;
         end else if (nxt_phase == upd_pkg::PH_DIG) begin
            chars[idx] = upd_pkg::CharPercent;
            idx        = idx + 2'd1;
            chars[idx] = nxt_held;
            idx        = idx + 2'd1;
         end
         nxt_phase = upd_pkg::PH_IDLE;
         if (idx != 2'd0) begin
            ends[idx - 2'd1] = 1'b1;
         end
      end

      dec.count = idx;
      dec.chars = chars;
      dec.ends  = ends;
      dec.phase = nxt_phase;
      dec.held  = nxt_held;
   end

endmodule

>>> sim/tb_url_percent_decoder.sv
// tb_url_percent_decoder: self-checking bench for the streaming percent decoder.
// Depends on upd_pkg and url_percent_decoder from the rtl folder.

module tb_url_percent_decoder;

   import upd_pkg::*;

   // Clock, reset and the two channels. All inputs are known from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   url_percent_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Encoded bytes waiting to be offered, and decoded characters still owed by
   // the block, oldest first.
   req_type pending_bytes[$];
   rsp_type expected_chars[$];
   rsp_type step_chars[$];
   rsp_type oldest_char;

   // Decoder state as the bench sees it: escape phase and the held hex digit.
   phase_type   dec_phase = PH_IDLE;
   logic [7:0]  dec_held  = '0;

   int beats_offered  = 0;
   int beats_taken    = 0;
   int bytes_queued   = 0;
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   bit rsp_hold       = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard limit: far beyond the slowest legal run (about 200 beats, three
   // characters each, every character waiting out the receiver's stalls).
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Hex digit check and value, either case.
   function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] value);
      hex_digit = 1'b1;
      value     = '0;
      if (c >= CharZero && c <= CharNine) begin
         value = 4'(c - CharZero);
      end else if (c >= CharLowerA && c <= CharLowerF) begin
         value = 4'(c - CharLowerA + 8'd10);
      end else if (c >= CharUpperA && c <= CharUpperF) begin
         value = 4'(c - CharUpperA + 8'd10);
      end else begin
         hex_digit = 1'b0;
      end
   endfunction

   function automatic void emit_char(input logic [7:0] c);
      rsp_type beat;
      beat.char_out      = c;
      beat.end_of_string = 1'b0;
      step_chars.push_back(beat);
   endfunction

   // A byte seen with no escape open: '+' is a space, '%' opens an escape.
   function automatic void decode_plain(input logic [7:0] c);
      if (c == CharPlus) begin
         emit_char(CharSpace);
      end else if (c == CharPercent) begin
         dec_phase = PH_PCT;
      end else begin
         emit_char(c);
      end
   endfunction

   // Works out the decoded characters one accepted request beat produces and
   // appends them to the expected queue.
   function automatic void decode_byte(input req_type beat);
      phase_type  was;
      logic [3:0] high_nib;
      logic [3:0] low_nib;
      rsp_type    last_char;
      was       = dec_phase;
      dec_phase = PH_IDLE;
      step_chars.delete();
      case (was)
         PH_PCT: begin
            if (beat.char_in == CharPercent) begin
               emit_char(CharPercent);
            end else if (hex_digit(beat.char_in, low_nib)) begin
               dec_held  = beat.char_in;
               dec_phase = PH_DIG;
            end else begin
               // broken escape: the '%' goes out as it stands
               emit_char(CharPercent);
               decode_plain(beat.char_in);
            end
         end
         PH_DIG: begin
            if (hex_digit(beat.char_in, low_nib)) begin
               void'(hex_digit(dec_held, high_nib));
               emit_char({high_nib, low_nib});
            end else begin
               // broken after one digit: '%' and the digit go out literally
               emit_char(CharPercent);
               emit_char(dec_held);
               decode_plain(beat.char_in);
            end
         end
         default: begin
            decode_plain(beat.char_in);
         end
      endcase
      if (beat.final_byte) begin
         // flush whatever escape is still open, then mark the last character
         if (dec_phase == PH_PCT) begin
            emit_char(CharPercent);
         end else if (dec_phase == PH_DIG) begin
            emit_char(CharPercent);
            emit_char(dec_held);
         end
         dec_phase = PH_IDLE;
         if (step_chars.size() > 0) begin
            last_char               = step_chars.pop_back();
            last_char.end_of_string = 1'b1;
            step_chars.push_back(last_char);
         end
      end
      foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   function automatic void push_byte(input logic [7:0] c, input bit last);
      req_type beat;
      beat.char_in    = c;
      beat.final_byte = last;
      pending_bytes.push_back(beat);
      bytes_queued++;
   endfunction

   // A whole string, final flag on its last byte.
   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
   endfunction

   function automatic logic [7:0] random_hex();
      int pick;
      pick = $urandom_range(0, 21);
      if (pick < 10) return 8'(CharZero + pick);
      if (pick < 16) return 8'(CharLowerA + pick - 10);
      return 8'(CharUpperA + pick - 16);
   endfunction

   // Any byte that cannot continue an escape.
   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      logic [3:0] ignored;
      do c = 8'($urandom_range(1, 255));
      while (hex_digit(c, ignored) || c == CharPercent);
      return c;
   endfunction

   // A well-formed string built from tokens: plain bytes, '+', "%%", good
   // escapes, escapes broken after '%' or after one digit, and bare openers
   // that get flushed when they land at the end of the string.
   function automatic void queue_string(input int tokens);
      logic [7:0] token_bytes[$];
      for (int t = 0; t < tokens; t++) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3: token_bytes.push_back(8'($urandom_range(1, 255)));
            4: token_bytes.push_back(CharPlus);
            5: begin
               token_bytes.push_back(CharPercent);
               token_bytes.push_back(CharPercent);
            end
            6, 7: begin
               token_bytes.push_back(CharPercent);
               token_bytes.push_back(random_hex());
               token_bytes.push_back(random_hex());
            end
            8: begin
               token_bytes.push_back(CharPercent);
               token_bytes.push_back(random_non_hex());
            end
            9: begin
               token_bytes.push_back(CharPercent);
               token_bytes.push_back(random_hex());
               token_bytes.push_back(random_non_hex());
            end
            10: token_bytes.push_back(CharPercent);
            default: begin
               token_bytes.push_back(CharPercent);
               token_bytes.push_back(random_hex());
            end
         endcase
      end
      foreach (token_bytes[i]) push_byte(token_bytes[i], i == token_bytes.size() - 1);
   endfunction

   // Mostly well-formed strings; about one in six is raw noise with the final
   // flag scattered at random.
   function automatic void queue_random(input int count);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               push_byte(8'($urandom_range(1, 255)), $urandom_range(0, 4) == 0);
            end
         end else begin
            queue_string($urandom_range(1, 6));
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver, receiver and monitor
   // ---------------------------------------------------------------------

   // Request side: a beat stays put until taken; between beats the sender may
   // idle. One assignment per signal per falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && beats_taken != beats_offered)) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            beats_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random back-pressure, plus a forced hold-off window.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Both handshakes are sampled at the rising edge. A request beat feeds the
   // prediction; a response beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_byte(req_data);
            beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("rsp beat %h/%b with no decoded character owed",
                      rsp_data.char_out, rsp_data.end_of_string);
               mismatch_count++;
            end else begin
               oldest_char = expected_chars.pop_front();
               if (rsp_data.char_out !== oldest_char.char_out) begin
                  $error("char_out: expected %h, got %h",
                         oldest_char.char_out, rsp_data.char_out);
                  mismatch_count++;
               end
               if (rsp_data.end_of_string !== oldest_char.end_of_string) begin
                  $error("end_of_string: expected %b, got %b",
                         oldest_char.end_of_string, rsp_data.end_of_string);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Every queued byte offered and taken.
   task automatic wait_all_taken();
      while (pending_bytes.size() != 0 || beats_taken != beats_offered) begin
         @(negedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      // first stretch: sender idles lightly, receiver heavily
      send_idle_pct = 22;
      recv_idle_pct = 56;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed strings: byte extremes, '+', "%%", escapes in both cases,
      // broken escape after '%', broken escape after one digit (both into '+'
      // for three characters from one beat, and into a fresh escape), and a
      // final byte arriving with '%' or '%' plus a digit still open.
      push_byte(8'h01, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_text("+");
      push_text("%%");
      push_text("%41%fF");
      push_text("%+");
      push_text("%B+");
      push_text("%3%6a");
      push_text("%");
      push_text("%9");
      queue_random(40);
      wait_all_taken();

      // second stretch: roles swapped
      send_idle_pct = 56;
      recv_idle_pct = 22;
      queue_random(40);
      wait_all_taken();

      // third stretch: nobody idles, but the receiver first holds off long
      // enough for the result buffer to fill and req_ready to drop
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(50);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (40) @(posedge clock);
      rsp_hold = 1'b0;
      wait_all_taken();

      // drain, then keep clocking so that anything stray from the block shows
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> url_percent_decoder.f
rtl/upd_pkg.sv
rtl/upd_decode.sv
rtl/url_percent_decoder.sv
sim/tb_url_percent_decoder.sv
